// ===== design/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // decoder phases
   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_BODY = 4'd1;
   localparam logic [3:0] PH_ESC  = 4'd2;
   localparam logic [3:0] PH_HEX1 = 4'd3;
   localparam logic [3:0] PH_BSL2 = 4'd4;
   localparam logic [3:0] PH_U2   = 4'd5;
   localparam logic [3:0] PH_HEX2 = 4'd6;

   // result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NO_QUOTE   = 3'd0;
   localparam logic [2:0] ERR_CONTROL    = 3'd1;
   localparam logic [2:0] ERR_BAD_ESC    = 3'd2;
   localparam logic [2:0] ERR_BAD_UNI    = 3'd3;
   localparam logic [2:0] ERR_END_ESC    = 3'd4;
   localparam logic [2:0] ERR_UNTERM     = 3'd5;

   // characters of interest
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // surrogate bounds
   localparam logic [15:0] HI_SUR_MIN = 16'hD800;
   localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
   localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
   localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE  = 21'h10000;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one group of results caused by a single request
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] err;
      logic [1:0] cnt_m1;   // number of results minus one
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
   } cmd_type;

   // hex digit decode: {valid, nibble}
   function automatic logic [4:0] hex_decode(logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   // utf-8 encoding of one code point into a data group
   function automatic cmd_type utf8_cmd(logic [20:0] cp);
      cmd_type c;
      c = '0;
      c.kind = KIND_DATA;
      c.err  = ERR_NO_QUOTE;
      if (cp < 21'h80) begin
         c.cnt_m1 = 2'd0;
         c.b0     = cp[7:0];
      end else if (cp < 21'h800) begin
         c.cnt_m1 = 2'd1;
         c.b0     = {3'b110, cp[10:6]};
         c.b1     = {2'b10, cp[5:0]};
      end else if (cp < SUPP_BASE) begin
         c.cnt_m1 = 2'd2;
         c.b0     = {4'b1110, cp[15:12]};
         c.b1     = {2'b10, cp[11:6]};
         c.b2     = {2'b10, cp[5:0]};
      end else begin
         c.cnt_m1 = 2'd3;
         c.b0     = {5'b11110, cp[20:18]};
         c.b1     = {2'b10, cp[17:12]};
         c.b2     = {2'b10, cp[11:6]};
         c.b3     = {2'b10, cp[5:0]};
      end
      return c;
   endfunction

endpackage

// ===== design/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Takes raw text bytes, tracks the string phase and \u escapes, and pushes
// one result group per request that causes any result.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_end_of_input,
   output logic              push,
   output jsu_pkg::cmd_type  push_cmd,
   input  logic              q_full
);

   logic [3:0]  phase_ff, phase_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] high_unit_ff, high_unit_in;
   logic [15:0] low_unit_ff, low_unit_in;

   logic             accept;
   logic             emit;
   jsu_pkg::cmd_type cmd;
   logic [4:0]       hex;
   logic [15:0]      unit_next;
   logic [20:0]      pair_cp;
   logic [7:0]       b;
   logic             eoi;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data_byte;
   assign eoi       = req_end_of_input;
   assign hex       = jsu_pkg::hex_decode(b);

   // shift the new digit into the unit being assembled
   assign unit_next = (phase_ff == jsu_pkg::PH_HEX1) ? {high_unit_ff[11:0], hex[3:0]}
                                                     : {low_unit_ff[11:0], hex[3:0]};
   // surrogate pair to code point
   assign pair_cp = jsu_pkg::SUPP_BASE + {1'b0, high_unit_ff[9:0], unit_next[9:0]};

   // next state and result group
   always_comb begin
      phase_in     = phase_ff;
      hex_count_in = hex_count_ff;
      high_unit_in = high_unit_ff;
      low_unit_in  = low_unit_ff;
      emit         = 1'b0;
      cmd          = '0;
      cmd.kind     = jsu_pkg::KIND_ERROR;
      cmd.err      = jsu_pkg::ERR_NO_QUOTE;
      unique case (phase_ff)
         jsu_pkg::PH_IDLE: begin
            if (!eoi) begin
               if (b == jsu_pkg::CH_QUOTE) begin
                  phase_in = jsu_pkg::PH_BODY;
               end else begin
                  emit = 1'b1;
               end
            end
         end
         jsu_pkg::PH_BODY: begin
            priority if (eoi) begin
               emit    = 1'b1;
               cmd.err = jsu_pkg::ERR_UNTERM;
            end else if (b == jsu_pkg::CH_QUOTE) begin
               emit     = 1'b1;
               cmd.kind = jsu_pkg::KIND_DONE;
               phase_in = jsu_pkg::PH_IDLE;
            end else if (b < jsu_pkg::CH_SPACE) begin
               emit    = 1'b1;
               cmd.err = jsu_pkg::ERR_CONTROL;
            end else if (b == jsu_pkg::CH_BSL) begin
               phase_in = jsu_pkg::PH_ESC;
            end else begin
               emit     = 1'b1;
               cmd.kind = jsu_pkg::KIND_DATA;
               cmd.b0   = b;
            end
         end
         jsu_pkg::PH_ESC: begin
            if (eoi) begin
               emit    = 1'b1;
               cmd.err = jsu_pkg::ERR_END_ESC;
            end else begin
               phase_in = jsu_pkg::PH_BODY;
               emit     = 1'b1;
               cmd.kind = jsu_pkg::KIND_DATA;
               unique case (b)
                  jsu_pkg::CH_QUOTE,
                  jsu_pkg::CH_BSL,
                  jsu_pkg::CH_SLASH: cmd.b0 = b;
                  jsu_pkg::CH_B:     cmd.b0 = 8'h08;
                  jsu_pkg::CH_F:     cmd.b0 = 8'h0C;
                  jsu_pkg::CH_N:     cmd.b0 = 8'h0A;
                  jsu_pkg::CH_R:     cmd.b0 = 8'h0D;
                  jsu_pkg::CH_T:     cmd.b0 = 8'h09;
                  jsu_pkg::CH_U: begin
                     emit         = 1'b0;
                     phase_in     = jsu_pkg::PH_HEX1;
                     hex_count_in = 2'd0;
                     high_unit_in = 16'd0;
                  end
                  default: begin
                     cmd.kind = jsu_pkg::KIND_ERROR;
                     cmd.err  = jsu_pkg::ERR_BAD_ESC;
                  end
               endcase
            end
         end
         jsu_pkg::PH_HEX1,
         jsu_pkg::PH_HEX2: begin
            if (eoi || !hex[4]) begin
               emit    = 1'b1;
               cmd.err = jsu_pkg::ERR_BAD_UNI;
            end else begin
               if (phase_ff == jsu_pkg::PH_HEX1) begin
                  high_unit_in = unit_next;
               end else begin
                  low_unit_in = unit_next;
               end
               if (hex_count_ff != 2'd3) begin
                  hex_count_in = hex_count_ff + 2'd1;
               end else begin
                  hex_count_in = 2'd0;
                  if (phase_ff == jsu_pkg::PH_HEX1) begin
                     if (unit_next >= jsu_pkg::HI_SUR_MIN &&
                         unit_next <= jsu_pkg::HI_SUR_MAX) begin
                        phase_in = jsu_pkg::PH_BSL2;
                     end else begin
                        phase_in = jsu_pkg::PH_BODY;
                        emit     = 1'b1;
                        cmd      = jsu_pkg::utf8_cmd({5'd0, unit_next});
                     end
                  end else if (unit_next < jsu_pkg::LO_SUR_MIN ||
                               unit_next > jsu_pkg::LO_SUR_MAX) begin
                     emit    = 1'b1;
                     cmd.err = jsu_pkg::ERR_BAD_UNI;
                  end else begin
                     phase_in = jsu_pkg::PH_BODY;
                     emit     = 1'b1;
                     cmd      = jsu_pkg::utf8_cmd(pair_cp);
                  end
               end
            end
         end
         jsu_pkg::PH_BSL2: begin
            if (eoi || b != jsu_pkg::CH_BSL) begin
               emit    = 1'b1;
               cmd.err = jsu_pkg::ERR_BAD_UNI;
            end else begin
               phase_in = jsu_pkg::PH_U2;
            end
         end
         jsu_pkg::PH_U2: begin
            if (eoi || b != jsu_pkg::CH_U) begin
               emit    = 1'b1;
               cmd.err = jsu_pkg::ERR_BAD_UNI;
            end else begin
               phase_in     = jsu_pkg::PH_HEX2;
               hex_count_in = 2'd0;
               low_unit_in  = 16'd0;
            end
         end
         default: begin
            phase_in     = jsu_pkg::PH_IDLE;
            hex_count_in = 2'd0;
         end
      endcase
      // any error returns to idle
      if (emit && cmd.kind == jsu_pkg::KIND_ERROR) begin
         phase_in     = jsu_pkg::PH_IDLE;
         hex_count_in = 2'd0;
      end
   end

   assign push     = accept && emit;
   assign push_cmd = cmd;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= jsu_pkg::PH_IDLE;
         hex_count_ff <= 2'd0;
         high_unit_ff <= 16'd0;
         low_unit_ff  <= 16'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         hex_count_ff <= hex_count_in;
         high_unit_ff <= high_unit_in;
         low_unit_ff  <= low_unit_in;
      end
   end

   // digit count only runs inside a \u escape
   a_hex_count_phase: assert property (@(posedge clock) disable iff (reset)
      hex_count_ff != 2'd0 |->
         (phase_ff == jsu_pkg::PH_HEX1 || phase_ff == jsu_pkg::PH_HEX2))
      else $error("hex digit count set outside a unicode escape");

   // a high surrogate is held while waiting for the low one
   a_high_held: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == jsu_pkg::PH_BSL2 || phase_ff == jsu_pkg::PH_U2) |->
         (high_unit_ff >= jsu_pkg::HI_SUR_MIN && high_unit_ff <= jsu_pkg::HI_SUR_MAX))
      else $error("waiting for low surrogate without a high surrogate");

endmodule

// ===== design/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Short first-in first-out queue of result groups between front and back.
// ----------------------------------------------------------------------------
module jsu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jsu_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output jsu_pkg::cmd_type  head_cmd
);

   jsu_pkg::cmd_type               slot_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [jsu_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign full      = count_ff == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_cmd  = slot_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // pointer distance matches occupancy
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff <= jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH) &&
      (wr_ptr_ff - rd_ptr_ff) == count_ff[jsu_pkg::QPTR_W-1:0])
      else $error("queue pointers disagree with count");

   // no overflow or underflow
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && !not_empty))
      else $error("queue overrun or underrun");

endmodule

// ===== design/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Takes result groups from the queue and presents their results one per
// cycle on the response channel while rsp_ready is high, marking the final one of each group.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  jsu_pkg::cmd_type  head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic [1:0]        rsp_kind,
   output logic [2:0]        rsp_error_code,
   output logic              rsp_last
);

   jsu_pkg::cmd_type cur_ff;
   logic             valid_ff;
   logic [1:0]       idx_ff;
   logic             done_group;

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = cur_ff.kind;
   assign rsp_error_code = cur_ff.err;
   assign rsp_last       = idx_ff == cur_ff.cnt_m1;

   // byte select within the group
   always_comb begin
      unique case (idx_ff)
         2'd0: rsp_out_byte = cur_ff.b0;
         2'd1: rsp_out_byte = cur_ff.b1;
         2'd2: rsp_out_byte = cur_ff.b2;
         default: rsp_out_byte = cur_ff.b3;
      endcase
   end

   assign done_group = !valid_ff || (rsp_ready && rsp_last);
   assign pop        = q_not_empty && done_group;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (done_group) begin
         valid_ff <= q_not_empty;
         idx_ff   <= 2'd0;
      end else if (rsp_ready) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   // group payload
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_cmd;
      end
   end

   // completion and error results stand alone
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && cur_ff.kind != jsu_pkg::KIND_DATA |-> rsp_last)
      else $error("status result not marked last");

   // a group in progress keeps going after a non-final response
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ready && !rsp_last |=> valid_ff && idx_ff == $past(idx_ff) + 2'd1)
      else $error("result group broken off");

endmodule

// ===== design/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming decoder of one JSON string literal into UTF-8 bytes.
// ----------------------------------------------------------------------------
// A request carries one text byte (or an end-of-input mark) and is accepted
// whenever the four-entry result queue has room, so text can stream at one
// byte per clock while the queue is not full. Each request that causes
// results puts one group of one to four results into the queue; the response
// side sends one result per cycle while rsp_ready is high and so sets the
// sustained rate; a \u escape that yields n UTF-8 bytes holds it until all n
// are sent. A result is registered in a queue slot, then in the back-end.
module json_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);

   logic             push;
   jsu_pkg::cmd_type push_cmd;
   logic             q_full;
   logic             pop;
   logic             q_not_empty;
   jsu_pkg::cmd_type head_cmd;

   // byte classifier and escape decoder
   jsu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .push             (push),
      .push_cmd         (push_cmd),
      .q_full           (q_full)
   );

   // result group queue
   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // result serializer
   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule
